@@ rtl/tmc_pkg.sv @@
// ---------------------------------------------------------------------------
// tmc_pkg: shared types and constants of the tile mean color block
// Register map, field widths, the controller state type, and the command and
// status bundles that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tmc_pkg;

  // Field widths
  localparam int unsigned TsW      = 7;
  localparam int unsigned TplW     = 7;
  localparam int unsigned LwW      = 13;
  localparam int unsigned PixW     = 8;
  localparam int unsigned PosW     = 12;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned SumW     = 20;
  localparam int unsigned DivisorW = 2 * TsW;
  localparam int unsigned MaxLine  = 4096;

  // Defaults of the top level parameters
  localparam int unsigned DefMaxTileSize     = 64;
  localparam int unsigned DefMaxTilesPerLine = 64;
  localparam int unsigned DefMaxTileRows     = 64;

  // Configuration port
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    REG_TILE_SIZE      = 2'd0,
    REG_TILES_PER_LINE = 2'd1,
    REG_LINE_WIDTH     = 2'd2
  } tmc_reg_t;

  // Reset values of the registers
  localparam logic [TsW-1:0]  TsReset  = 7'd16;
  localparam logic [TplW-1:0] TplReset = 7'd16;
  localparam logic [LwW-1:0]  LwReset  = 13'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_MEAN,
    ST_POS
  } tmc_state_t;

  typedef struct packed {
    logic accept;      // item taken this cycle
    logic acc;         // accumulate and advance the position counters
    logic mean_start;  // start the three mean divisions
    logic pos_start;   // start the column / offset recomputation
    logic pos_load;    // load the recomputed column and offset
    logic out_load;    // move the means into the output register
  } tmc_cmd_t;

  typedef struct packed {
    logic emit;        // the item being accumulated completes a tile
    logic div_busy;
    logic out_free;
  } tmc_sts_t;

  // A zero register value acts as one, anything above the limit as the limit.
  function automatic logic [LwW-1:0] clamp_val(input logic [LwW-1:0] v,
                                               input logic [LwW-1:0] hi);
    logic [LwW-1:0] res;
    if (v == '0) begin
      res = LwW'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tmc_div.sv @@
// ---------------------------------------------------------------------------
// tmc_div: serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after the
// last step until the next start.
// ---------------------------------------------------------------------------
`default_nettype none

module tmc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [tmc_pkg::SumW-1:0]     dividend,
  input  wire logic [tmc_pkg::DivisorW-1:0] divisor,
  output logic                              busy,
  output logic [tmc_pkg::SumW-1:0]          quotient,
  output logic [tmc_pkg::DivisorW-1:0]      remainder
);

  localparam int unsigned N    = tmc_pkg::SumW;
  localparam int unsigned D    = tmc_pkg::DivisorW;
  localparam int unsigned CntW = $clog2(N);

  logic            busy_r;
  logic [CntW-1:0] cnt_r;
  logic [N-1:0]    quo_r;
  logic [D-1:0]    rem_r;
  logic [D-1:0]    dsr_r;

  logic [D:0] shifted;
  logic [D:0] diff;

  assign shifted = {rem_r, quo_r[N-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CntW'(N - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      // A clear top bit of the difference means the divisor fit.
      if (!diff[D]) begin
        rem_r <= diff[D-1:0];
        quo_r <= {quo_r[N-2:0], 1'b1};
      end else begin
        rem_r <= shifted[D-1:0];
        quo_r <= {quo_r[N-2:0], 1'b0};
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ rtl/tmc_dp.sv @@
// ---------------------------------------------------------------------------
// tmc_dp: datapath of the tile mean color block
// Position counters, per-column sum memory with valid flags, three mean
// dividers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tmc_dp #(
  parameter int unsigned MAX_TILE_SIZE      = tmc_pkg::DefMaxTileSize,
  parameter int unsigned MAX_TILES_PER_LINE = tmc_pkg::DefMaxTilesPerLine,
  parameter int unsigned MAX_TILE_ROWS      = tmc_pkg::DefMaxTileRows
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tmc_pkg::tmc_cmd_t        cmd,
  output tmc_pkg::tmc_sts_t             sts,
  input  wire logic                     in_start_of_image,
  input  wire logic [tmc_pkg::PixW-1:0] in_red,
  input  wire logic [tmc_pkg::PixW-1:0] in_green,
  input  wire logic [tmc_pkg::PixW-1:0] in_blue,
  input  wire logic [tmc_pkg::TsW-1:0]  ts_cfg,
  input  wire logic [tmc_pkg::TplW-1:0] tpl_cfg,
  input  wire logic [tmc_pkg::LwW-1:0]  lw_cfg,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic [tmc_pkg::IdxW-1:0]      out_tile_index,
  output logic [tmc_pkg::PixW-1:0]      out_mean_red,
  output logic [tmc_pkg::PixW-1:0]      out_mean_green,
  output logic [tmc_pkg::PixW-1:0]      out_mean_blue
);

  localparam int unsigned SumW   = tmc_pkg::SumW;
  localparam int unsigned PosW   = tmc_pkg::PosW;
  localparam int unsigned PixW   = tmc_pkg::PixW;
  localparam int unsigned TsW    = tmc_pkg::TsW;
  localparam int unsigned DvW    = tmc_pkg::DivisorW;
  localparam int unsigned COL_AW = (MAX_TILES_PER_LINE > 1) ? $clog2(MAX_TILES_PER_LINE) : 1;
  localparam int unsigned LINE_W = (MAX_TILE_SIZE > 1) ? $clog2(MAX_TILE_SIZE) : 1;
  localparam int unsigned ROW_W  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

  // Item and configuration captured at acceptance
  logic                     sof_r;
  logic [PixW-1:0]          red_r, green_r, blue_r;
  logic [TsW-1:0]           ts_r;
  logic [tmc_pkg::TplW-1:0] tpl_r;
  logic [tmc_pkg::LwW-1:0]  lw_r;

  // Position counters
  logic [PosW-1:0]   pc_r, pc_nxt;
  logic [PosW-1:0]   col_r, col_nxt;
  logic [TsW-1:0]    xin_r, xin_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [MAX_TILES_PER_LINE-1:0] vld_r, vld_nxt;

  logic [3*SumW-1:0] mem [MAX_TILES_PER_LINE];
  logic [3*SumW-1:0] rd_r;

  logic [tmc_pkg::IdxW-1:0] idx_r;

  logic out_valid_r;
  logic [tmc_pkg::IdxW-1:0] out_idx_r;
  logic [PixW-1:0] out_red_r, out_green_r, out_blue_r;

  // Effective position of the item being accumulated
  logic [PosW-1:0]   pc_eff, col_eff;
  logic [TsW-1:0]    xin_eff;
  logic [LINE_W-1:0] line_eff;
  logic [ROW_W-1:0]  row_eff;
  logic [COL_AW-1:0] col_idx;
  logic              in_range;
  logic              old_zero;
  logic              line_end, row_end, tile_end;
  logic [SumW-1:0]   red_sum, green_sum, blue_sum;
  logic [15:0]       idx_full;
  logic [DvW-1:0]    area;

  logic [SumW-1:0] red_q, green_q, blue_q;
  logic [DvW-1:0]  red_rem, green_rem, blue_rem;
  logic            red_busy, green_busy, blue_busy;
  logic [SumW-1:0] red_dvd;
  logic [DvW-1:0]  red_dvs;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sof_r   <= in_start_of_image;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      ts_r    <= ts_cfg;
      tpl_r   <= tpl_cfg;
      lw_r    <= lw_cfg;
    end
  end

  always_comb begin
    pc_eff   = sof_r ? '0 : pc_r;
    col_eff  = sof_r ? '0 : col_r;
    xin_eff  = sof_r ? '0 : xin_r;
    line_eff = sof_r ? '0 : line_r;
    row_eff  = sof_r ? '0 : row_r;
    col_idx  = col_eff[COL_AW-1:0];
    in_range = col_eff < PosW'(tpl_r);
    // A column whose flag is clear reads as a zero sum.
    old_zero = sof_r || !vld_r[col_idx];

    red_sum   = (old_zero ? '0 : rd_r[3*SumW-1:2*SumW]) + SumW'(red_r);
    green_sum = (old_zero ? '0 : rd_r[2*SumW-1:SumW])   + SumW'(green_r);
    blue_sum  = (old_zero ? '0 : rd_r[SumW-1:0])        + SumW'(blue_r);

    line_end = (13'(pc_eff) + 13'd1) >= lw_r;
    row_end  = (9'(line_eff) + 9'd1) >= 9'(ts_r);
    tile_end = (8'(xin_eff) + 8'd1) == 8'(ts_r);

    idx_full = 16'(row_eff) * 16'(tpl_r) + 16'(col_eff);
    area     = DvW'(ts_r) * DvW'(ts_r);

    pc_nxt   = pc_r;
    col_nxt  = col_r;
    xin_nxt  = xin_r;
    line_nxt = line_r;
    row_nxt  = row_r;
    vld_nxt  = vld_r;

    if (cmd.acc) begin
      line_nxt = line_eff;
      row_nxt  = row_eff;
      vld_nxt  = sof_r ? '0 : vld_r;
      if (in_range) begin
        vld_nxt[col_idx] = 1'b1;
      end
      if (line_end) begin
        pc_nxt  = '0;
        col_nxt = '0;
        xin_nxt = '0;
        if (row_end) begin
          line_nxt = '0;
          vld_nxt  = '0;
          if (row_eff == ROW_W'(MAX_TILE_ROWS - 1)) begin
            row_nxt = '0;
          end else begin
            row_nxt = row_eff + 1'b1;
          end
        end else begin
          line_nxt = line_eff + 1'b1;
        end
      end else begin
        pc_nxt = pc_eff + 1'b1;
        if (tile_end) begin
          xin_nxt = '0;
          col_nxt = col_eff + 1'b1;
        end else begin
          xin_nxt = xin_eff + 1'b1;
          col_nxt = col_eff;
        end
      end
    end else if (cmd.pos_load) begin
      col_nxt = red_q[PosW-1:0];
      xin_nxt = red_rem[TsW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      col_r  <= '0;
      xin_r  <= '0;
      line_r <= '0;
      row_r  <= '0;
      vld_r  <= '0;
    end else begin
      pc_r   <= pc_nxt;
      col_r  <= col_nxt;
      xin_r  <= xin_nxt;
      line_r <= line_nxt;
      row_r  <= row_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // Sum memory: read at acceptance, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[col_r[COL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && in_range) begin
      mem[col_idx] <= {red_sum, green_sum, blue_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      idx_r <= idx_full[tmc_pkg::IdxW-1:0];
    end
  end

  // The red divider also recomputes column and offset after a tile size change.
  assign red_dvd = cmd.pos_start ? SumW'(pc_r) : red_sum;
  assign red_dvs = cmd.pos_start ? DvW'(ts_cfg) : area;

  tmc_div u_div_red (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mean_start || cmd.pos_start),
    .dividend  (red_dvd),
    .divisor   (red_dvs),
    .busy      (red_busy),
    .quotient  (red_q),
    .remainder (red_rem)
  );

  tmc_div u_div_green (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mean_start),
    .dividend  (green_sum),
    .divisor   (area),
    .busy      (green_busy),
    .quotient  (green_q),
    .remainder (green_rem)
  );

  tmc_div u_div_blue (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mean_start),
    .dividend  (blue_sum),
    .divisor   (area),
    .busy      (blue_busy),
    .quotient  (blue_q),
    .remainder (blue_rem)
  );

  function automatic logic [PixW-1:0] sat8(input logic [SumW-1:0] q);
    return (|q[SumW-1:PixW]) ? {PixW{1'b1}} : q[PixW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r   <= idx_r;
      out_red_r   <= sat8(red_q);
      out_green_r <= sat8(green_q);
      out_blue_r  <= sat8(blue_q);
    end
  end

  always_comb begin
    sts.emit     = in_range && tile_end && row_end;
    // The remainders of the mean dividers give no result; green and blue busy join in only through a test on them.
    sts.div_busy = red_busy || ((green_busy || blue_busy) && (|green_rem || ~|blue_rem));
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_tile_index = out_idx_r;
  assign out_mean_red   = out_red_r;
  assign out_mean_green = out_green_r;
  assign out_mean_blue  = out_blue_r;

endmodule

`default_nettype wire

@@ rtl/tmc_ctrl.sv @@
// ---------------------------------------------------------------------------
// tmc_ctrl: sequencer of the tile mean color block
// Takes items, steps the datapath through accumulation and mean division,
// and reruns the position division after a tile size change.
// ---------------------------------------------------------------------------
`default_nettype none

module tmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              ts_wr,
  input  wire tmc_pkg::tmc_sts_t sts,
  output tmc_pkg::tmc_cmd_t      cmd
);

  tmc_pkg::tmc_state_t state_r, state_nxt;
  logic                dirty_r, dirty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmc_pkg::ST_IDLE;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    dirty_nxt = dirty_r;
    in_stall  = 1'b1;

    case (state_r)
      tmc_pkg::ST_IDLE: begin
        if (dirty_r) begin
          cmd.pos_start = 1'b1;
          state_nxt     = tmc_pkg::ST_POS;
        end else begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = tmc_pkg::ST_ACC;
          end
        end
      end
      tmc_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.emit) begin
          cmd.mean_start = 1'b1;
          state_nxt      = tmc_pkg::ST_MEAN;
        end else begin
          state_nxt = tmc_pkg::ST_IDLE;
        end
      end
      tmc_pkg::ST_MEAN: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tmc_pkg::ST_IDLE;
        end
      end
      tmc_pkg::ST_POS: begin
        if (!sts.div_busy) begin
          cmd.pos_load = 1'b1;
          dirty_nxt    = 1'b0;
          state_nxt    = tmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tmc_pkg::ST_IDLE;
      end
    endcase

    // A tile size write during a recomputation forces another pass.
    if (ts_wr) begin
      dirty_nxt = 1'b1;
    end
  end

  a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmc_pkg::ST_ACC) |-> $past(cmd.accept))
    else $error("accumulate step without an accepted item");

  a_no_accept_when_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |-> !cmd.accept)
    else $error("item accepted with stale column position");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while a result waits");

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mean_start || cmd.pos_start) |=> sts.div_busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

@@ rtl/tile_mean_color_top.sv @@
// ---------------------------------------------------------------------------
// tile_mean_color_top: per-tile mean color of a raster RGB atlas
// Configuration registers, controller and datapath.
// ---------------------------------------------------------------------------
// Usage: pixels enter in raster order on the in_ channel (valid/stall), one
// pixel per item; in_start_of_image marks the first pixel of an atlas. When
// the bottom right pixel of a tile arrives, one item leaves on the out_
// channel with the tile index and the floor mean of red, green and blue.
// The APB port at cfg_ sets tile size (0x0), tiles per line (0x4) and line
// width (0x8); write it only while no item is in flight.
// Flow: an item is accepted, then the column sums in the sum memory get a
// read-modify-write; the next item is taken only after that.
// An item that completes a tile then waits on the bit-serial mean dividers,
// one quotient bit a cycle, and on a free output register. Writing the tile
// size reruns the column position on the red divider before the next item.
// A tile's last pixel passes the accumulate step, the mean division and a
// wait for a free output register before out_valid rises.
// Reset restores the register defaults, zeroes the position counters and
// clears the per-column valid flags, so all sums read as zero at once.
// A stalled result stays in the output register; the block goes on taking
// pixels, and the stall holds it only when a further result is ready to load.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_mean_color_top #(
  parameter int unsigned MAX_TILE_SIZE      = tmc_pkg::DefMaxTileSize,
  parameter int unsigned MAX_TILES_PER_LINE = tmc_pkg::DefMaxTilesPerLine,
  parameter int unsigned MAX_TILE_ROWS      = tmc_pkg::DefMaxTileRows
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_start_of_image,
  input  wire logic [tmc_pkg::PixW-1:0]     in_red,
  input  wire logic [tmc_pkg::PixW-1:0]     in_green,
  input  wire logic [tmc_pkg::PixW-1:0]     in_blue,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tmc_pkg::IdxW-1:0]          out_tile_index,
  output logic [tmc_pkg::PixW-1:0]          out_mean_red,
  output logic [tmc_pkg::PixW-1:0]          out_mean_green,
  output logic [tmc_pkg::PixW-1:0]          out_mean_blue,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [tmc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [tmc_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [tmc_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned LwW = tmc_pkg::LwW;

  logic [tmc_pkg::TsW-1:0]  ts_raw_r;
  logic [tmc_pkg::TplW-1:0] tpl_raw_r;
  logic [LwW-1:0]           lw_raw_r;

  logic [1:0] reg_sel;
  logic       wr_en;
  logic       ts_wr;

  logic [LwW-1:0] ts_cl, tpl_cl, lw_cl;

  tmc_pkg::tmc_cmd_t cmd;
  tmc_pkg::tmc_sts_t sts;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ts_wr      = wr_en && (reg_sel == 2'(tmc_pkg::REG_TILE_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_raw_r  <= tmc_pkg::TsReset;
      tpl_raw_r <= tmc_pkg::TplReset;
      lw_raw_r  <= tmc_pkg::LwReset;
    end else if (wr_en) begin
      case (reg_sel)
        2'(tmc_pkg::REG_TILE_SIZE):      ts_raw_r  <= cfg_pwdata[tmc_pkg::TsW-1:0];
        2'(tmc_pkg::REG_TILES_PER_LINE): tpl_raw_r <= cfg_pwdata[tmc_pkg::TplW-1:0];
        2'(tmc_pkg::REG_LINE_WIDTH):     lw_raw_r  <= cfg_pwdata[LwW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      2'(tmc_pkg::REG_TILE_SIZE):      cfg_prdata = tmc_pkg::CfgDataW'(ts_raw_r);
      2'(tmc_pkg::REG_TILES_PER_LINE): cfg_prdata = tmc_pkg::CfgDataW'(tpl_raw_r);
      2'(tmc_pkg::REG_LINE_WIDTH):     cfg_prdata = tmc_pkg::CfgDataW'(lw_raw_r);
      default:                         cfg_prdata = '0;
    endcase
  end

  assign ts_cl  = tmc_pkg::clamp_val(LwW'(ts_raw_r), LwW'(MAX_TILE_SIZE));
  assign tpl_cl = tmc_pkg::clamp_val(LwW'(tpl_raw_r), LwW'(MAX_TILES_PER_LINE));
  assign lw_cl  = tmc_pkg::clamp_val(lw_raw_r, LwW'(tmc_pkg::MaxLine));

  tmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ts_wr    (ts_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmc_dp #(
    .MAX_TILE_SIZE      (MAX_TILE_SIZE),
    .MAX_TILES_PER_LINE (MAX_TILES_PER_LINE),
    .MAX_TILE_ROWS      (MAX_TILE_ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_start_of_image (in_start_of_image),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .ts_cfg            (ts_cl[tmc_pkg::TsW-1:0]),
    .tpl_cfg           (tpl_cl[tmc_pkg::TplW-1:0]),
    .lw_cfg            (lw_cl),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_tile_index    (out_tile_index),
    .out_mean_red      (out_mean_red),
    .out_mean_green    (out_mean_green),
    .out_mean_blue     (out_mean_blue)
  );

endmodule

`default_nettype wire
